@@ rtl/core/pwq_pkg.sv @@
// Package for the priority work queue: field widths, command and status
// codes, and the packed layout of one queue entry.
// No dependencies; used by the top level and the checker under rtl/core.
package pwq_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int CMD_W   = 2;
    localparam int TAG_W   = 16;
    localparam int PRIO_W  = 8;
    localparam int EVENT_W = 8;
    localparam int PART_W  = 8;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_FLUSH   = 2'd2,
        CMD_REMOVE  = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [PRIO_W-1:0]  prio;
        logic [EVENT_W-1:0] ev;
        logic [PART_W-1:0]  part;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/core/pwq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the queue entries of the priority work queue.
module pwq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/priority_work_queue_dedup.sv @@
// Top level of the priority work queue with duplicate rejection.
// Depends on pwq_pkg and on pwq_ram for entry storage.
//
// The queue holds up to DEPTH entries in one RAM, kept in service order
// (higher priority first, arrival order among equals). One command is
// worked at a time and in_ready is low until its result has been loaded
// into the output register; a new command is taken while that result still
// waits for out_ready. Enqueue, remove and a dequeue from a non-empty
// queue walk the RAM through its single read and single write port, one
// entry per cycle; flush and a dequeue from an empty queue do not walk it.
// Loading the result waits while the output register still holds one that
// out_ready has not taken. The threshold event code is written through
// the cfg channel, which is always ready, and must
// only be written while no command is in progress.
module priority_work_queue_dedup #(
    parameter int DEPTH = pwq_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pwq_pkg::CMD_W-1:0]   cmd,
    input  logic [pwq_pkg::TAG_W-1:0]   item_tag,
    input  logic [pwq_pkg::PRIO_W-1:0]  item_priority,
    input  logic [pwq_pkg::EVENT_W-1:0] event_type,
    input  logic [pwq_pkg::PART_W-1:0]  participant,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pwq_pkg::STAT_W-1:0]  status,
    output logic [pwq_pkg::TAG_W-1:0]   head_tag,
    output logic [pwq_pkg::PRIO_W-1:0]  head_priority,
    output logic [pwq_pkg::EVENT_W-1:0] head_event,
    output logic [pwq_pkg::PART_W-1:0]  head_participant,
    output logic [pwq_pkg::COUNT_W-1:0] removed_count,
    output logic [pwq_pkg::COUNT_W-1:0] entry_count,
    output logic [pwq_pkg::COUNT_W-1:0] peak_count,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pwq_pkg::EVENT_W-1:0] cfg_data
);

    import pwq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    entry_t                 item_reg, item_next;
    logic [EVENT_W-1:0]     thr_reg, thr_next;
    logic [CNT_W-1:0]       occ_reg, occ_next;
    logic [CNT_W-1:0]       peak_reg, peak_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]       wr_cnt_reg, wr_cnt_next;
    logic [CNT_W-1:0]       rem_cnt_reg, rem_cnt_next;
    logic                   dup_reg, dup_next;
    logic                   pos_found_reg, pos_found_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       moves_reg, moves_next;
    logic [IDX_W-1:0]       sh_addr_reg, sh_addr_next;
    entry_t                 head_reg, head_next;
    status_t                stat_reg, stat_next;

    logic                   out_valid_reg, out_valid_next;
    status_t                out_stat_reg, out_stat_next;
    entry_t                 out_head_reg, out_head_next;
    logic [CNT_W-1:0]       out_rem_reg, out_rem_next;
    logic [CNT_W-1:0]       out_occ_reg, out_occ_next;
    logic [CNT_W-1:0]       out_peak_reg, out_peak_next;

    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    entry_t                 ram_wr_data;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [ENTRY_W-1:0]     ram_rd_bits;

    entry_t                 rd_entry;
    logic                   key_match;
    logic                   drop;
    logic [CNT_W-1:0]       pos_sel;
    logic [CNT_W-1:0]       occ_inc;

    // Entry storage
    pwq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_bits)
    );

    assign rd_entry  = entry_t'(ram_rd_bits);
    assign key_match = (rd_entry.ev == item_reg.ev) && (rd_entry.part == item_reg.part);
    assign drop      = (cmd_reg == CMD_DEQUEUE) ? (pend_idx_reg == '0) : key_match;
    assign pos_sel   = pos_found_reg ? pos_reg : occ_reg;
    assign occ_inc   = CNT_W'(occ_reg + 1'b1);

    // Sequencer: walk the RAM one entry per cycle
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        item_next      = item_reg;
        thr_next       = thr_reg;
        occ_next       = occ_reg;
        peak_next      = peak_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        wr_cnt_next    = wr_cnt_reg;
        rem_cnt_next   = rem_cnt_reg;
        dup_next       = dup_reg;
        pos_found_next = pos_found_reg;
        pos_next       = pos_reg;
        moves_next     = moves_reg;
        sh_addr_next   = sh_addr_reg;
        head_next      = head_reg;
        stat_next      = stat_reg;

        out_valid_next = out_valid_reg;
        out_stat_next  = out_stat_reg;
        out_head_next  = out_head_reg;
        out_rem_next   = out_rem_reg;
        out_occ_next   = out_occ_reg;
        out_peak_next  = out_peak_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = rd_entry;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;

        // Take the configuration write
        if (cfg_valid)
        begin
            thr_next = cfg_data;
        end

        // Drop the result once taken
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next       = cmd_t'(cmd);
                    item_next      = '{tag: item_tag, prio: item_priority,
                                       ev: event_type, part: participant};
                    idx_next       = '0;
                    wr_cnt_next    = '0;
                    rem_cnt_next   = '0;
                    dup_next       = 1'b0;
                    pos_found_next = 1'b0;
                    head_next      = '0;
                    stat_next      = ST_OK;
                    case (cmd_t'(cmd))
                        CMD_FLUSH:
                        begin
                            occ_next   = '0;
                            state_next = S_FINISH;
                        end
                        CMD_DEQUEUE:
                        begin
                            if (occ_reg == '0)
                            begin
                                stat_next  = ST_EMPTY;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue the next read
                if (idx_reg < occ_reg)
                begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = idx_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                    idx_next      = CNT_W'(idx_reg + 1'b1);
                end

                // Examine the entry read last cycle
                if (pend_reg)
                begin
                    if (cmd_reg == CMD_ENQUEUE)
                    begin
                        if (key_match && (item_reg.ev == thr_reg))
                        begin
                            dup_next = 1'b1;
                        end
                        if (!pos_found_reg && (item_reg.prio > rd_entry.prio))
                        begin
                            pos_found_next = 1'b1;
                            pos_next       = CNT_W'(pend_idx_reg);
                        end
                    end
                    else if (drop)
                    begin
                        // Dequeue keeps the head; remove counts the match
                        if (cmd_reg == CMD_DEQUEUE)
                        begin
                            head_next = rd_entry;
                        end
                        else
                        begin
                            rem_cnt_next = CNT_W'(rem_cnt_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        // Compact the survivors towards the head
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = wr_cnt_reg[IDX_W-1:0];
                        ram_wr_data = rd_entry;
                        wr_cnt_next = CNT_W'(wr_cnt_reg + 1'b1);
                    end
                end

                // Walk complete
                if (!pend_reg && (idx_reg >= occ_reg))
                begin
                    if (cmd_reg == CMD_ENQUEUE)
                    begin
                        if (dup_reg)
                        begin
                            stat_next  = ST_DUP;
                            state_next = S_FINISH;
                        end
                        else if (occ_reg >= CNT_W'(DEPTH))
                        begin
                            stat_next  = ST_FULL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            pos_next     = pos_sel;
                            moves_next   = CNT_W'(occ_reg - pos_sel);
                            sh_addr_next = IDX_W'(occ_reg - 1'b1);
                            state_next   = S_SHIFT;
                        end
                    end
                    else
                    begin
                        occ_next   = wr_cnt_reg;
                        state_next = S_FINISH;
                    end
                end
            end

            S_SHIFT:
            begin
                // Read from the tail down to the insertion point
                if (moves_reg != '0)
                begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = sh_addr_reg;
                    pend_next     = 1'b1;
                    pend_idx_next = sh_addr_reg;
                    sh_addr_next  = IDX_W'(sh_addr_reg - 1'b1);
                    moves_next    = CNT_W'(moves_reg - 1'b1);
                end

                if (pend_reg)
                begin
                    // Move the entry up by one slot
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = IDX_W'(pend_idx_reg + 1'b1);
                    ram_wr_data = rd_entry;
                end
                else if (moves_reg == '0)
                begin
                    // Insert the new item into the gap
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = pos_reg[IDX_W-1:0];
                    ram_wr_data = item_reg;
                    occ_next    = occ_inc;
                    if (occ_inc > peak_reg)
                    begin
                        peak_next = occ_inc;
                    end
                    state_next  = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_head_next  = head_reg;
                    out_rem_next   = rem_cnt_reg;
                    out_occ_next   = occ_reg;
                    out_peak_next  = peak_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_ENQUEUE;
            item_reg      <= '0;
            thr_reg       <= '0;
            occ_reg       <= '0;
            peak_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            wr_cnt_reg    <= '0;
            rem_cnt_reg   <= '0;
            dup_reg       <= 1'b0;
            pos_found_reg <= 1'b0;
            pos_reg       <= '0;
            moves_reg     <= '0;
            sh_addr_reg   <= '0;
            head_reg      <= '0;
            stat_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
            out_stat_reg  <= ST_OK;
            out_head_reg  <= '0;
            out_rem_reg   <= '0;
            out_occ_reg   <= '0;
            out_peak_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            item_reg      <= item_next;
            thr_reg       <= thr_next;
            occ_reg       <= occ_next;
            peak_reg      <= peak_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            wr_cnt_reg    <= wr_cnt_next;
            rem_cnt_reg   <= rem_cnt_next;
            dup_reg       <= dup_next;
            pos_found_reg <= pos_found_next;
            pos_reg       <= pos_next;
            moves_reg     <= moves_next;
            sh_addr_reg   <= sh_addr_next;
            head_reg      <= head_next;
            stat_reg      <= stat_next;
            out_valid_reg <= out_valid_next;
            out_stat_reg  <= out_stat_next;
            out_head_reg  <= out_head_next;
            out_rem_reg   <= out_rem_next;
            out_occ_reg   <= out_occ_next;
            out_peak_reg  <= out_peak_next;
        end
    end

    // Port drive
    assign in_ready         = (state_reg == S_IDLE);
    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign status           = out_stat_reg;
    assign head_tag         = out_head_reg.tag;
    assign head_priority    = out_head_reg.prio;
    assign head_event       = out_head_reg.ev;
    assign head_participant = out_head_reg.part;
    assign removed_count    = COUNT_W'(out_rem_reg);
    assign entry_count      = COUNT_W'(out_occ_reg);
    assign peak_count       = COUNT_W'(out_peak_reg);

endmodule

@@ rtl/core/pwq_checker.sv @@
// Port-level checker for the priority work queue, bound to the top level.
// Depends on pwq_pkg for the status codes.
module pwq_checker #(
    parameter int DEPTH = pwq_pkg::DEPTH_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [pwq_pkg::STAT_W-1:0]  status,
    input logic [pwq_pkg::TAG_W-1:0]   head_tag,
    input logic [pwq_pkg::COUNT_W-1:0] removed_count,
    input logic [pwq_pkg::COUNT_W-1:0] entry_count
);

    import pwq_pkg::*;

    // One transaction at a time: busy right after an accepted command
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after an accepted transaction");

    // Hold a stalled result
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(head_tag) && $stable(entry_count))
        else $error("stalled result changed");

    // An empty dequeue reports an empty queue and no head
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> (entry_count == '0) && (head_tag == '0))
        else $error("empty dequeue reported entries or a head");

    // A full rejection reports a full queue
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> entry_count == COUNT_W'(DEPTH))
        else $error("full rejection with queue not full");

    // Only a successful command can remove entries
    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> removed_count == '0)
        else $error("rejected transaction reported removed entries");

endmodule

bind priority_work_queue_dedup pwq_checker #(.DEPTH(DEPTH)) u_pwq_checker (.*);
